// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhsm: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RHSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhsm: assertion failed");

`endif

// ===== sv/rhsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsm_pkg
// Types, constants and modular arithmetic helpers for the rolling hash
// substring match unit.
// ----------------------------------------------------------------------------
package rhsm_pkg;

    typedef enum logic [1:0] {
        REQ_FIRST = 2'd0,
        REQ_MORE  = 2'd1,
        REQ_TEXT  = 2'd2
    } req_type_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

    localparam logic [29:0]     HASH_MOD    = 30'd1000000007;
    localparam longint unsigned HASH_MOD_L  = 64'd1000000007;
    localparam logic [6:0]      CODE_OFFSET = 7'd96;

    // Base multiples of the modulus for each value of the top eight bits
    function automatic logic [255:0][36:0] build_red_tbl();
        logic [255:0][36:0] tbl;
        longint unsigned    q;
        for (int t = 0; t < 256; t++)
        begin
            q      = (longint'(t) << 29) / HASH_MOD_L;
            tbl[t] = 37'(q * HASH_MOD_L);
        end
        return tbl;
    endfunction

    localparam logic [255:0][36:0] RED_TBL = build_red_tbl();

    // Reduce a 37-bit value modulo the hash modulus
    function automatic logic [29:0] red37(input logic [36:0] x);
        logic [36:0] r;
        r = x - RED_TBL[x[36:29]];
        if (r >= {7'b0, HASH_MOD})
        begin
            r = r - {7'b0, HASH_MOD};
        end
        return r[29:0];
    endfunction

    function automatic logic [29:0] mul31(input logic [29:0] v);
        logic [36:0] x;
        x = ({7'b0, v} << 5) - {7'b0, v};
        return red37(x);
    endfunction

    function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HASH_MOD})
        begin
            s = s - {1'b0, HASH_MOD};
        end
        return s[29:0];
    endfunction

    function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
        logic [30:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (s[30])
        begin
            s = s + {1'b0, HASH_MOD};
        end
        return s[29:0];
    endfunction

endpackage

// ===== sv/rhsm_ring.sv =====
// ----------------------------------------------------------------------------
// rhsm_ring
// Prefix hash ring: one write port and one registered read port. A read and
// a write to the same entry at one edge return the old contents.
// ----------------------------------------------------------------------------
module rhsm_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  rhsm_pkg::ring_ctl_t ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [29:0]         wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [29:0]         rd_data
);
    import rhsm_pkg::*;

    logic [29:0] mem [DEPTH];
    logic [29:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rolling_hash_substring_match_unit.sv =====
// A text letter's match passes stages 1, 2, 3 and the output register to match_valid.
// Throughput: one letter per cycle; the pipeline freezes only while a result is held.
// The prefix ring is read and written in the same stage, so no forwarding is needed.
// Reset clears all hash state, counters and valid flags; ring contents stay undefined
// and are never read before being written.
// ----------------------------------------------------------------------------
// rolling_hash_substring_match_unit
// Rabin-Karp matcher: pattern letters build the pattern hash, text letters
// build prefix hashes kept in a ring and compared window by window.
// ----------------------------------------------------------------------------
module rolling_hash_substring_match_unit #(
    parameter int MAX_PATTERN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [6:0]  letter,
    output logic        match_valid,
    input  logic        match_stall,
    output logic [31:0] match_start
);
    import rhsm_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_PATTERN);
    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_PATTERN - 1);
    localparam logic [AW:0]   RING_SPAN = (AW + 1)'(MAX_PATTERN);

    // front state
    logic [LW-1:0] pat_len_reg, pat_len_next;
    logic          too_long_reg, too_long_next;
    logic [29:0]   power_reg, power_next;
    logic [31:0]   text_count_reg, text_count_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;

    // hash state
    logic [29:0] pat_hash_reg;
    logic [29:0] prefix_hash_reg;
    logic [29:0] scaled_hash_reg;

    // stage 1
    logic          s1_valid_reg, s1_pat_reg, s1_clear_reg, s1_first_reg;
    logic          s1_win_reg, s1_older_reg, s1_too_long_reg;
    logic [31:0]   s1_start_reg;
    logic [AW-1:0] s1_raddr_reg, s1_waddr_reg;
    logic [36:0]   s1_prod_reg;

    // stage 2
    logic          s2_valid_reg, s2_pat_reg, s2_clear_reg, s2_first_reg;
    logic          s2_win_reg, s2_older_reg, s2_too_long_reg;
    logic [31:0]   s2_start_reg;
    logic [AW-1:0] s2_raddr_reg, s2_waddr_reg;
    logic [29:0]   s2_term_reg;

    // stage 3
    logic        s3_cand_reg, s3_older_reg;
    logic [31:0] s3_start_reg;

    // output
    logic        out_valid_reg;
    logic [31:0] out_start_reg;

    logic          advance, accept;
    logic [6:0]    code;
    logic          s0_live, s0_pat, s0_clear, s0_first, step_power;
    logic [29:0]   power_use;
    logic [31:0]   pat_len_ext;
    logic          s0_win, s0_older;
    logic [31:0]   s0_start;
    logic [AW:0]   rd_diff;
    logic [36:0]   s0_prod;

    logic [29:0]   pat_base, prefix_new;
    ring_ctl_t     ring_ctl;
    logic [29:0]   ring_rdata;
    logic [29:0]   older_hash, window_hash;
    logic          hit;

    assign advance   = !out_valid_reg || !match_stall;
    assign req_stall = !advance;
    assign accept    = req_valid && advance;
    assign code      = letter - CODE_OFFSET;

    always_comb
    begin
        pat_len_next    = pat_len_reg;
        too_long_next   = too_long_reg;
        text_count_next = text_count_reg;
        wr_ptr_next     = wr_ptr_reg;
        power_next      = power_reg;
        s0_live         = 1'b0;
        s0_pat          = 1'b0;
        s0_clear        = 1'b0;
        s0_first        = 1'b0;
        step_power      = 1'b0;
        power_use       = power_reg;
        case (req_type)
            REQ_FIRST:
            begin
                s0_live         = 1'b1;
                s0_pat          = 1'b1;
                s0_clear        = 1'b1;
                power_use       = 30'd1;
                step_power      = 1'b1;
                pat_len_next    = LW'(1);
                too_long_next   = 1'b0;
                text_count_next = '0;
                wr_ptr_next     = '0;
            end
            REQ_MORE:
            begin
                if (text_count_reg == '0)
                begin
                    if (pat_len_reg == LEN_MAX)
                    begin
                        too_long_next = 1'b1;
                    end
                    else
                    begin
                        s0_live      = 1'b1;
                        s0_pat       = 1'b1;
                        step_power   = 1'b1;
                        pat_len_next = pat_len_reg + 1'b1;
                    end
                end
            end
            REQ_TEXT:
            begin
                if (text_count_reg != '1)
                begin
                    s0_live         = 1'b1;
                    s0_first        = (text_count_reg == '0);
                    power_use       = s0_first ? 30'd1 : power_reg;
                    step_power      = 1'b1;
                    text_count_next = text_count_reg + 32'd1;
                    wr_ptr_next     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (step_power)
        begin
            power_next = mul31(power_use);
        end
    end

    always_comb
    begin
        pat_len_ext = 32'(pat_len_reg);
        s0_win      = (pat_len_reg != '0) && (text_count_reg >= pat_len_ext - 32'd1);
        s0_older    = (text_count_reg != pat_len_ext - 32'd1);
        s0_start    = text_count_reg - pat_len_ext + 32'd1;
        rd_diff     = {1'b0, wr_ptr_reg} - (AW + 1)'(pat_len_reg);
        if (rd_diff[AW])
        begin
            rd_diff = rd_diff + RING_SPAN;
        end
        s0_prod     = {30'b0, code} * {7'b0, power_use};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg    <= '0;
            too_long_reg   <= 1'b0;
            power_reg      <= 30'd1;
            text_count_reg <= '0;
            wr_ptr_reg     <= '0;
        end
        else if (accept)
        begin
            pat_len_reg    <= pat_len_next;
            too_long_reg   <= too_long_next;
            power_reg      <= power_next;
            text_count_reg <= text_count_next;
            wr_ptr_reg     <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_cand_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept && s0_live;
            s2_valid_reg  <= s1_valid_reg;
            s3_cand_reg   <= s2_valid_reg && !s2_pat_reg && s2_win_reg && !s2_too_long_reg;
            out_valid_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pat_reg      <= s0_pat;
            s1_clear_reg    <= s0_clear;
            s1_first_reg    <= s0_first;
            s1_win_reg      <= s0_win;
            s1_older_reg    <= s0_older;
            s1_too_long_reg <= too_long_reg;
            s1_start_reg    <= s0_start;
            s1_raddr_reg    <= rd_diff[AW-1:0];
            s1_waddr_reg    <= wr_ptr_reg;
            s1_prod_reg     <= s0_prod;

            s2_pat_reg      <= s1_pat_reg;
            s2_clear_reg    <= s1_clear_reg;
            s2_first_reg    <= s1_first_reg;
            s2_win_reg      <= s1_win_reg;
            s2_older_reg    <= s1_older_reg;
            s2_too_long_reg <= s1_too_long_reg;
            s2_start_reg    <= s1_start_reg;
            s2_raddr_reg    <= s1_raddr_reg;
            s2_waddr_reg    <= s1_waddr_reg;
            s2_term_reg     <= red37(s1_prod_reg);

            s3_older_reg    <= s2_older_reg;
            s3_start_reg    <= s2_start_reg;

            out_start_reg   <= s3_start_reg;
        end
    end

    assign pat_base   = s2_clear_reg ? '0 : pat_hash_reg;
    assign prefix_new = add_mod(prefix_hash_reg, s2_term_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_hash_reg    <= '0;
            prefix_hash_reg <= '0;
            scaled_hash_reg <= '0;
        end
        else if (advance && s2_valid_reg)
        begin
            if (s2_pat_reg)
            begin
                pat_hash_reg <= add_mod(pat_base, s2_term_reg);
                if (s2_clear_reg)
                begin
                    prefix_hash_reg <= '0;
                    scaled_hash_reg <= '0;
                end
            end
            else
            begin
                prefix_hash_reg <= prefix_new;
                if (s2_first_reg)
                begin
                    scaled_hash_reg <= pat_hash_reg;
                end
                else if (s2_win_reg && s2_older_reg)
                begin
                    scaled_hash_reg <= mul31(scaled_hash_reg);
                end
            end
        end
    end

    assign ring_ctl.wr_en = advance && s2_valid_reg && !s2_pat_reg;
    assign ring_ctl.rd_en = advance && s2_valid_reg && !s2_pat_reg && s2_win_reg && s2_older_reg;

    rhsm_ring #(
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .ctl     (ring_ctl),
        .wr_addr (s2_waddr_reg),
        .wr_data (prefix_new),
        .rd_addr (s2_raddr_reg),
        .rd_data (ring_rdata)
    );

    assign older_hash  = s3_older_reg ? ring_rdata : '0;
    assign window_hash = sub_mod(prefix_hash_reg, older_hash);
    assign hit         = s3_cand_reg && (window_hash == scaled_hash_reg);

    assign match_valid = out_valid_reg;
    assign match_start = out_start_reg;

endmodule

// ===== sv/rhsm_checker.sv =====
// ----------------------------------------------------------------------------
// rhsm_checker
// Port-level checks on the match unit: result hold, stall cause and
// result timing against the pipeline advance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        match_valid,
    input logic        match_stall,
    input logic [31:0] match_start
);

    `RHSM_ASSERT_NEXT(a_result_hold, match_valid && match_stall, match_valid && $stable(match_start))
    `RHSM_ASSERT_NOW(a_stall_cause, req_stall, match_valid && match_stall)
    `RHSM_ASSERT_NOW(a_rise_on_advance, $rose(match_valid), $past(!req_stall))
    `RHSM_ASSERT_NOW(a_fall_on_take, $fell(match_valid), $past(!match_stall))

endmodule

bind rolling_hash_substring_match_unit rhsm_checker u_rhsm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_stall   (req_stall),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match_start (match_start)
);
